/* rtl/core/lzg_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzg_pkg
// Shared constants and controller/datapath interface types for the encoder.
// ----------------------------------------------------------------------------
package lzg_pkg;

   localparam int WINDOW_DEPTH    = 4096;
   localparam int LOOKAHEAD_DEPTH = 32;
   localparam int WIN_AW          = $clog2(WINDOW_DEPTH);
   localparam int DIST_W          = 13;
   localparam int LEN_W           = 6;
   localparam int LA_AW           = $clog2(LOOKAHEAD_DEPTH);

   localparam logic [1:0] CSR_MIN_MATCH = 2'd0;
   localparam logic [1:0] CSR_MAX_DIST  = 2'd1;

   localparam logic [LEN_W-1:0]  MIN_MATCH_RESET = LEN_W'(3);
   localparam logic [DIST_W-1:0] MAX_DIST_RESET  = DIST_W'(4096);

   typedef struct packed {
      logic accept;
      logic search_init;
      logic start_dist;
      logic fetch;
      logic cmp_step;
      logic end_dist;
      logic emit;
      logic consume;
      logic flush_clear;
   } cmd_type;

   typedef struct packed {
      logic last_fill;
      logic limit_zero;
      logic len_at_max;
      logic byte_eq;
      logic dist_one;
      logic rsp_free;
      logic cons_last;
      logic final_seen;
      logic la_empty_after;
   } status_type;

endpackage

/* rtl/core/lzg_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzg_ram
// Generic simple dual-port ram with registered read.
// ----------------------------------------------------------------------------
module lzg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/lzg_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzg_ctrl
// Sequencer for intake, match search, token emit and lookahead consume.
// ----------------------------------------------------------------------------
module lzg_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  lzg_pkg::status_type status,
   output lzg_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_INIT, ST_START, ST_FETCH, ST_CMP, ST_ENDD, ST_EMIT, ST_CONS
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (status.last_fill) state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            cmd.search_init = 1'b1;
            state_in = status.limit_zero ? ST_EMIT : ST_START;
         end
         ST_START: begin
            cmd.start_dist = 1'b1;
            state_in = ST_FETCH;
         end
         ST_FETCH: begin
            if (status.len_at_max) begin
               state_in = ST_ENDD;
            end else begin
               cmd.fetch = 1'b1;
               state_in  = ST_CMP;
            end
         end
         ST_CMP: begin
            if (status.byte_eq) begin
               cmd.cmp_step = 1'b1;
               state_in = ST_FETCH;
            end else begin
               state_in = ST_ENDD;
            end
         end
         ST_ENDD: begin
            cmd.end_dist = 1'b1;
            state_in = status.dist_one ? ST_EMIT : ST_START;
         end
         ST_EMIT: begin
            if (status.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = ST_CONS;
            end
         end
         ST_CONS: begin
            cmd.consume = 1'b1;
            if (status.cons_last) begin
               if (!status.final_seen) begin
                  state_in = ST_IDLE;
               end else if (status.la_empty_after) begin
                  cmd.flush_clear = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_INIT;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/core/lzg_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzg_dp
// Lookahead, history window, match counters, config and result registers.
// ----------------------------------------------------------------------------
module lzg_dp (
   input  logic                               clock,
   input  logic                               reset,
   input  lzg_pkg::cmd_type                   cmd,
   output lzg_pkg::status_type                status,
   input  logic [7:0]                         req_data_byte,
   input  logic                               req_final_byte,
   input  logic                               csr_valid,
   input  logic [1:0]                         csr_index,
   input  logic [lzg_pkg::DIST_W-1:0]         csr_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_is_match,
   output logic [7:0]                         rsp_literal_byte,
   output logic [lzg_pkg::DIST_W-1:0]         rsp_match_offset,
   output logic [lzg_pkg::LEN_W-1:0]          rsp_match_length,
   output logic                               rsp_run_end,
   output logic                               rsp_stream_end
);

   localparam int LA = lzg_pkg::LOOKAHEAD_DEPTH;
   localparam int AW = lzg_pkg::WIN_AW;
   localparam int DW = lzg_pkg::DIST_W;
   localparam int LW = lzg_pkg::LEN_W;

   logic [7:0]    la_ff [LA];
   logic [LW-1:0] la_fill_ff;
   logic [DW-1:0] hist_fill_ff;
   logic [AW-1:0] wp_ff;
   logic [LW-1:0] cfg_min_ff;
   logic [DW-1:0] cfg_dist_ff;
   logic          fin_ff;
   logic [DW-1:0] dist_ff;
   logic [LW-1:0] len_ff;
   logic [AW-1:0] mod_ff;
   logic [LW-1:0] best_ff;
   logic [DW-1:0] best_off_ff;
   logic [LW-1:0] cnt_ff;
   logic          rsp_valid_ff;
   logic          is_match_ff;
   logic [7:0]    lit_ff;
   logic [DW-1:0] off_ff;
   logic [LW-1:0] mlen_ff;
   logic          run_end_ff;
   logic          stream_end_ff;

   logic [DW-1:0] limit;
   logic [LW-1:0] minm;
   logic [AW-1:0] rd_addr;
   logic [7:0]    rd_data;
   logic [LW-1:0] take;
   logic [DW-1:0] mod_next;

   always_comb begin
      limit = cfg_dist_ff;
      if (limit > hist_fill_ff) limit = hist_fill_ff;
      if (limit > DW'(lzg_pkg::WINDOW_DEPTH)) limit = DW'(lzg_pkg::WINDOW_DEPTH);
   end

   assign minm     = (cfg_min_ff < LW'(1)) ? LW'(1) : cfg_min_ff;
   assign rd_addr  = wp_ff - dist_ff[AW-1:0] + mod_ff;
   assign take     = (best_ff != '0) ? best_ff : LW'(1);
   assign mod_next = DW'(mod_ff) + DW'(1);

   lzg_ram #(.WIDTH(8), .DEPTH(lzg_pkg::WINDOW_DEPTH)) u_hist (
      .clock   (clock),
      .wr_en   (cmd.consume),
      .wr_addr (wp_ff),
      .wr_data (la_ff[0]),
      .rd_en   (cmd.fetch),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign status.last_fill      = req_final_byte || (la_fill_ff == LW'(LA - 1));
   assign status.limit_zero     = (limit == '0);
   assign status.len_at_max     = (len_ff == la_fill_ff);
   assign status.byte_eq        = (rd_data == la_ff[len_ff[lzg_pkg::LA_AW-1:0]]);
   assign status.dist_one       = (dist_ff == DW'(1));
   assign status.rsp_free       = !rsp_valid_ff || rsp_ready;
   assign status.cons_last      = (cnt_ff == LW'(1));
   assign status.final_seen     = fin_ff;
   assign status.la_empty_after = (la_fill_ff == LW'(1));

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         la_fill_ff   <= '0;
         hist_fill_ff <= '0;
         wp_ff        <= '0;
         cfg_min_ff   <= lzg_pkg::MIN_MATCH_RESET;
         cfg_dist_ff  <= lzg_pkg::MAX_DIST_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            if (csr_index == lzg_pkg::CSR_MIN_MATCH) cfg_min_ff <= csr_data[LW-1:0];
            if (csr_index == lzg_pkg::CSR_MAX_DIST) cfg_dist_ff <= csr_data;
         end
         if (cmd.accept) la_fill_ff <= la_fill_ff + LW'(1);
         if (cmd.flush_clear) begin
            wp_ff        <= '0;
            hist_fill_ff <= '0;
            la_fill_ff   <= '0;
         end else if (cmd.consume) begin
            wp_ff      <= wp_ff + AW'(1);
            la_fill_ff <= la_fill_ff - LW'(1);
            if (hist_fill_ff < DW'(lzg_pkg::WINDOW_DEPTH)) begin
               hist_fill_ff <= hist_fill_ff + DW'(1);
            end
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         la_ff[la_fill_ff[lzg_pkg::LA_AW-1:0]] <= req_data_byte;
         fin_ff <= req_final_byte;
      end
      if (cmd.consume) begin
         for (int i = 0; i < LA - 1; i++) la_ff[i] <= la_ff[i+1];
         cnt_ff <= cnt_ff - LW'(1);
      end
      if (cmd.search_init) begin
         dist_ff     <= limit;
         best_ff     <= '0;
         best_off_ff <= '0;
      end
      if (cmd.start_dist) begin
         len_ff <= '0;
         mod_ff <= '0;
      end
      if (cmd.cmp_step) begin
         len_ff <= len_ff + LW'(1);
         mod_ff <= (mod_next == dist_ff) ? '0 : mod_next[AW-1:0];
      end
      if (cmd.end_dist) begin
         if (len_ff >= minm && len_ff > best_ff) begin
            best_ff     <= len_ff;
            best_off_ff <= dist_ff;
         end
         dist_ff <= dist_ff - DW'(1);
      end
      if (cmd.emit) begin
         is_match_ff   <= (best_ff != '0);
         lit_ff        <= (best_ff != '0) ? 8'd0 : la_ff[0];
         off_ff        <= best_off_ff;
         mlen_ff       <= best_ff;
         run_end_ff    <= !fin_ff || (la_fill_ff == take);
         stream_end_ff <= fin_ff && (la_fill_ff == take);
         cnt_ff        <= take;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_is_match     = is_match_ff;
   assign rsp_literal_byte = lit_ff;
   assign rsp_match_offset = off_ff;
   assign rsp_match_length = mlen_ff;
   assign rsp_run_end      = run_end_ff;
   assign rsp_stream_end   = stream_end_ff;

endmodule

/* rtl/core/lz77_greedy_encoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz77_greedy_encoder
// Streaming greedy longest-match LZ77 encoder with a 4096-byte window.
//
//   channel  dir  ports               word
//   req      in   valid/ready         data_byte, final_byte
//   rsp      out  valid/ready         is_match .. stream_end
//   csr      in   valid/ready         index, data
//
// A byte not filling the lookahead is taken while idle. A token search runs a
// setup step, then per distance a start step, fetch and compare steps per
// compared byte (a final fetch step if the match hits the lookahead fill) and
// an end step on the single history read port, then an emit step and a consume
// step per consumed byte. Reset is synchronous; the window needs no clearing
// pass. A token waits in the output register while the next search runs.
// ----------------------------------------------------------------------------
module lz77_greedy_encoder (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [7:0]                 req_data_byte,
   input  logic                       req_final_byte,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_is_match,
   output logic [7:0]                 rsp_literal_byte,
   output logic [lzg_pkg::DIST_W-1:0] rsp_match_offset,
   output logic [lzg_pkg::LEN_W-1:0]  rsp_match_length,
   output logic                       rsp_run_end,
   output logic                       rsp_stream_end,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [1:0]                 csr_index,
   input  logic [lzg_pkg::DIST_W-1:0] csr_data
);

   lzg_pkg::cmd_type    cmd;
   lzg_pkg::status_type status;

   assign csr_ready = 1'b1;

   lzg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lzg_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_data_byte    (req_data_byte),
      .req_final_byte   (req_final_byte),
      .csr_valid        (csr_valid),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_is_match     (rsp_is_match),
      .rsp_literal_byte (rsp_literal_byte),
      .rsp_match_offset (rsp_match_offset),
      .rsp_match_length (rsp_match_length),
      .rsp_run_end      (rsp_run_end),
      .rsp_stream_end   (rsp_stream_end)
   );

endmodule

/* rtl/core/lzg_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzg_checker
// Port-level checks on the encoder token stream.
// ----------------------------------------------------------------------------
module lzg_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic                       rsp_is_match,
   input logic [7:0]                 rsp_literal_byte,
   input logic [lzg_pkg::DIST_W-1:0] rsp_match_offset,
   input logic [lzg_pkg::LEN_W-1:0]  rsp_match_length,
   input logic                       rsp_run_end,
   input logic                       rsp_stream_end
);

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_match_offset)
         && $stable(rsp_literal_byte) && $stable(rsp_is_match))
      else $error("stalled word changed");

   a_match_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_match |-> rsp_literal_byte == 8'd0
         && rsp_match_length != '0 && rsp_match_offset != '0)
      else $error("bad match word");

   a_literal_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_match |-> rsp_match_length == '0 && rsp_match_offset == '0)
      else $error("bad literal word");

   a_end_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stream_end |-> rsp_run_end)
      else $error("stream end without run end");

endmodule

bind lz77_greedy_encoder lzg_checker u_lzg_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_is_match     (rsp_is_match),
   .rsp_literal_byte (rsp_literal_byte),
   .rsp_match_offset (rsp_match_offset),
   .rsp_match_length (rsp_match_length),
   .rsp_run_end      (rsp_run_end),
   .rsp_stream_end   (rsp_stream_end)
);

/* test/lz77_greedy_encoder_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz77_greedy_encoder_checker
// Watches the byte, token and register channels of the encoder. It queues
// the tokens that each accepted byte causes, found by its own greedy
// longest-match search over a private copy of the window and lookahead, and
// compares every accepted token field by field against the oldest queued one.
// ----------------------------------------------------------------------------
module lz77_greedy_encoder_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic [7:0]                 req_data_byte,
   input  logic                       req_final_byte,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic                       rsp_is_match,
   input  logic [7:0]                 rsp_literal_byte,
   input  logic [lzg_pkg::DIST_W-1:0] rsp_match_offset,
   input  logic [lzg_pkg::LEN_W-1:0]  rsp_match_length,
   input  logic                       rsp_run_end,
   input  logic                       rsp_stream_end,
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  logic [1:0]                 csr_index,
   input  logic [lzg_pkg::DIST_W-1:0] csr_data,
   output int                         errors,
   output int                         pending
);
   import lzg_pkg::*;

   typedef struct {
      logic              is_match;
      logic [7:0]        literal_byte;
      logic [DIST_W-1:0] match_offset;
      logic [LEN_W-1:0]  match_length;
      logic              run_end;
      logic              stream_end;
   } token_type;

   logic [7:0]        window_mem [WINDOW_DEPTH];
   logic [7:0]        ahead_mem [LOOKAHEAD_DEPTH];
   int                window_fill;
   int                window_wp;
   int                ahead_fill;
   logic [LEN_W-1:0]  min_match;
   logic [DIST_W-1:0] max_dist;
   token_type         token_q [$];

   assign pending = token_q.size();

   function automatic logic [7:0] candidate_byte(int d, int k);
      if (k < d)
         return window_mem[(window_wp + WINDOW_DEPTH - ((d - k) % WINDOW_DEPTH)) % WINDOW_DEPTH];
      return ahead_mem[(k - d) % LOOKAHEAD_DEPTH];
   endfunction

   function automatic void retire_bytes(int n);
      if (n > ahead_fill) n = ahead_fill;
      for (int i = 0; i < n; i++) begin
         window_mem[window_wp] = ahead_mem[i];
         window_wp = (window_wp + 1) % WINDOW_DEPTH;
         if (window_fill < WINDOW_DEPTH) window_fill++;
      end
      for (int i = 0; i < ahead_fill - n; i++) ahead_mem[i] = ahead_mem[i + n];
      ahead_fill -= n;
   endfunction

   function automatic token_type search_token();
      token_type t;
      int limit, minm, best, best_d, len;
      limit = max_dist;
      if (limit > window_fill) limit = window_fill;
      minm = (min_match < 1) ? 1 : min_match;
      best = 0;
      best_d = 0;
      for (int d = limit; d >= 1; d--) begin
         len = 0;
         while (len < ahead_fill && candidate_byte(d, len) == ahead_mem[len]) len++;
         if (len >= minm && len > best) begin
            best = len;
            best_d = d;
         end
      end
      t.run_end = 1'b0;
      t.stream_end = 1'b0;
      if (best > 0) begin
         t.is_match = 1'b1;
         t.literal_byte = '0;
         t.match_offset = DIST_W'(best_d);
         t.match_length = LEN_W'(best);
         retire_bytes(best);
      end else begin
         t.is_match = 1'b0;
         t.literal_byte = ahead_mem[0];
         t.match_offset = '0;
         t.match_length = '0;
         retire_bytes(1);
      end
      return t;
   endfunction

   function automatic void predict_byte(logic [7:0] b, logic fin);
      token_type t;
      int n;
      n = 0;
      if (ahead_fill < LOOKAHEAD_DEPTH) begin
         ahead_mem[ahead_fill] = b;
         ahead_fill++;
      end
      if (!fin) begin
         if (ahead_fill >= LOOKAHEAD_DEPTH) begin
            t = search_token();
            t.run_end = 1'b1;
            token_q.insert(token_q.size(), t);
         end
         return;
      end
      while (ahead_fill > 0 && n < LOOKAHEAD_DEPTH) begin
         t = search_token();
         if (ahead_fill == 0 || n == LOOKAHEAD_DEPTH - 1) begin
            t.run_end = 1'b1;
            t.stream_end = 1'b1;
         end
         token_q.insert(token_q.size(), t);
         n++;
      end
      window_fill = 0;
      window_wp = 0;
      ahead_fill = 0;
   endfunction

   always @(posedge clock) begin
      token_type e;
      if (reset) begin
         window_fill = 0;
         window_wp = 0;
         ahead_fill = 0;
         min_match <= MIN_MATCH_RESET;
         max_dist <= MAX_DIST_RESET;
         errors <= 0;
         token_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_MIN_MATCH) min_match <= csr_data[LEN_W-1:0];
            else if (csr_index == CSR_MAX_DIST) max_dist <= csr_data;
         end
         if (req_valid && req_ready) predict_byte(req_data_byte, req_final_byte);
         if (rsp_valid && rsp_ready) begin
            if (token_q.size() == 0) begin
               $error("unexpected token word");
               errors <= errors + 1;
            end else begin
               e = token_q.pop_front();
               if (rsp_is_match !== e.is_match ||
                   rsp_literal_byte !== e.literal_byte ||
                   rsp_match_offset !== e.match_offset ||
                   rsp_match_length !== e.match_length ||
                   rsp_run_end !== e.run_end ||
                   rsp_stream_end !== e.stream_end)
                  errors <= errors + 1;
               if (rsp_is_match !== e.is_match)
                  $error("is_match expected %0d got %0d", e.is_match, rsp_is_match);
               if (rsp_literal_byte !== e.literal_byte)
                  $error("literal_byte expected %0d got %0d", e.literal_byte, rsp_literal_byte);
               if (rsp_match_offset !== e.match_offset)
                  $error("match_offset expected %0d got %0d", e.match_offset, rsp_match_offset);
               if (rsp_match_length !== e.match_length)
                  $error("match_length expected %0d got %0d", e.match_length, rsp_match_length);
               if (rsp_run_end !== e.run_end)
                  $error("run_end expected %0d got %0d", e.run_end, rsp_run_end);
               if (rsp_stream_end !== e.stream_end)
                  $error("stream_end expected %0d got %0d", e.stream_end, rsp_stream_end);
            end
         end
      end
   end

endmodule

/* test/lz77_greedy_encoder_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz77_greedy_encoder_tb
// Feeds short byte streams (random, small-alphabet and periodic) through the
// encoder under several register settings and idle patterns, including a long
// token-side hold-off, while the checker predicts and compares every token.
// ----------------------------------------------------------------------------
module lz77_greedy_encoder_tb;
   import lzg_pkg::*;

   localparam logic [1:0] CSR_UNUSED = 2'd3;

   logic              clock;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [7:0]        req_data_byte = '0;
   logic              req_final_byte = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic              rsp_is_match;
   logic [7:0]        rsp_literal_byte;
   logic [DIST_W-1:0] rsp_match_offset;
   logic [LEN_W-1:0]  rsp_match_length;
   logic              rsp_run_end;
   logic              rsp_stream_end;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [1:0]        csr_index = '0;
   logic [DIST_W-1:0] csr_data = '0;
   int                errors;
   int                pending;
   int                tx_idle = 0;
   int                rx_stall = 0;
   logic              hold_rsp = 1'b0;

   lz77_greedy_encoder uut (.*);
   lz77_greedy_encoder_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("tb: failure");
      $finish;
   end

   always @(posedge clock)
      rsp_ready <= !hold_rsp && ($urandom_range(99) >= rx_stall);

   task automatic send_byte(logic [7:0] b, logic fin);
      while ($urandom_range(99) < tx_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_final_byte <= fin;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [DIST_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic send_stream(int len, int mode);
      logic [7:0] pat [8];
      int period, alpha;
      logic [7:0] b;
      period = $urandom_range(1, 8);
      alpha = $urandom_range(2, 4);
      for (int i = 0; i < 8; i++) pat[i] = 8'($urandom);
      for (int i = 0; i < len; i++) begin
         case (mode)
            0: b = 8'($urandom);
            1: b = pat[$urandom_range(0, alpha - 1)];
            default: b = ($urandom_range(9) == 0) ? 8'($urandom) : pat[i % period];
         endcase
         send_byte(b, i == len - 1);
      end
   endtask

   int min_set  [6] = '{3, 2, 32, 2, 5, 4};
   int dist_set [6] = '{4096, 1, 4096, 4096, 7, 100};
   int tx_set   [6] = '{0, 82, 0, 22, 0, 82};
   int rx_set   [6] = '{0, 0, 82, 22, 0, 0};

   initial begin
      int sent, len;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_byte(8'hFF, 1'b1);
      for (int i = 0; i < 20; i++) send_byte((i % 2) ? 8'h55 : 8'h00, i == 19);
      send_byte(8'hAA, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h01, 1'b1);
      drain();
      write_reg(CSR_UNUSED, '1);

      for (int p = 0; p < 6; p++) begin
         write_reg(CSR_MIN_MATCH, DIST_W'(min_set[p]));
         write_reg(CSR_MAX_DIST, DIST_W'(dist_set[p]));
         tx_idle = tx_set[p];
         rx_stall = rx_set[p];
         if (p == 0) begin
            fork
               begin
                  hold_rsp <= 1'b1;
                  repeat (600) @(posedge clock);
                  hold_rsp <= 1'b0;
               end
            join_none
         end
         sent = 0;
         while (sent < 42) begin
            len = ($urandom_range(9) < 7) ? $urandom_range(33, 60) : $urandom_range(1, 32);
            if (len > 42 - sent) len = 42 - sent;
            send_stream(len, $urandom_range(2));
            sent += len;
            if (p == 1 && sent < 42) begin
               req_valid <= 1'b0;
               @(posedge clock);
               while (pending != 0) @(posedge clock);
            end
         end
         drain();
      end

      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
